@@ sv/batched_broadcast_matmul_assert.svh @@
// assertion macros for the batched matmul block
`ifndef BATCHED_BROADCAST_MATMUL_ASSERT_SVH
`define BATCHED_BROADCAST_MATMUL_ASSERT_SVH

// same-cycle implication
`define BBM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bbm_pkg.sv @@
`default_nettype none
package bbm_pkg;

  typedef enum logic [1:0] {
    OP_WR_A = 2'd0,
    OP_WR_B = 2'd1,
    OP_DOT  = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHAPE = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_WR_A,
    CMD_WR_B,
    CMD_DOT,
    CMD_ERR
  } kind_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_RUN,
    BS_WAIT,
    BS_FIN
  } back_state_t;

  localparam logic [2:0] REG_ROWS_M  = 3'd0;
  localparam logic [2:0] REG_INNER_K = 3'd1;
  localparam logic [2:0] REG_COLS_N  = 3'd2;
  localparam logic [2:0] REG_BATCH_A = 3'd3;
  localparam logic [2:0] REG_BATCH_B = 3'd4;

  localparam int Q_DEPTH = 4;

  typedef struct packed {
    opcode_t            opcode;
    logic [11:0]        address;
    logic signed [15:0] element_value;
    logic [3:0]         batch_index;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
  } item_t;

  typedef struct packed {
    logic signed [31:0] dot_value;
    status_t            status;
  } result_t;

  typedef struct packed {
    logic [6:0] rows_m;
    logic [6:0] inner_k;
    logic [6:0] cols_n;
    logic [4:0] batch_a;
    logic [4:0] batch_b;
  } cfg_t;

  // one queued word between front and back
  typedef struct packed {
    kind_t       kind;
    logic [15:0] addr_a;
    logic [15:0] addr_b;
    logic [15:0] data;
    logic [6:0]  len_k;
    logic [6:0]  stride_n;
    status_t     status;
  } cmd_t;

endpackage
`default_nettype wire

@@ sv/batched_broadcast_matmul.sv @@
// Writes: one word per cycle while busy is low; a write passes the front stages and
// the queue before it lands in its store. Compute: the back end reads one A/B element
// pair per cycle from the stores, inner_k per dot product; it pops nothing until idle.
// Errored computes are popped in IDLE and skip RUN. done pulses one cycle, no stall.
// rst (sync, high) clears control and sets each config register to 1; stores undefined.
`default_nettype none
module batched_broadcast_matmul
  import bbm_pkg::*;
#(
  parameter int MEM_DEPTH  = 4096,
  parameter int MAX_DIM    = 64,
  parameter int MAX_BATCH  = 16,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [6:0] cfg_data,
  input  wire logic       start,
  input  wire item_t      item,
  output logic            busy,
  output logic            done,
  output result_t         result
);

  `include "batched_broadcast_matmul_assert.svh"

  cfg_t cfg;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows_m  <= 7'd1;
      cfg.inner_k <= 7'd1;
      cfg.cols_n  <= 7'd1;
      cfg.batch_a <= 5'd1;
      cfg.batch_b <= 5'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROWS_M:  cfg.rows_m  <= cfg_data;
        REG_INNER_K: cfg.inner_k <= cfg_data;
        REG_COLS_N:  cfg.cols_n  <= cfg_data;
        REG_BATCH_A: cfg.batch_a <= cfg_data[4:0];
        REG_BATCH_B: cfg.batch_b <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  bbm_front #(
    .MEM_DEPTH (MEM_DEPTH),
    .MAX_DIM   (MAX_DIM),
    .MAX_BATCH (MAX_BATCH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .q_push (q_push),
    .q_cmd  (q_wdata),
    .q_full (q_full)
  );

  bbm_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  bbm_back #(
    .MEM_DEPTH  (MEM_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_cmd   (q_rdata),
    .q_pop   (q_pop),
    .done    (done),
    .result  (result)
  );

  `BBM_ASSERT_IMPL(a_err_zero, done && (result.status == ST_SHAPE || result.status == ST_RANGE), result.dot_value == 32'sd0, "error word with nonzero value")
  `BBM_ASSERT_IMPL(a_sat_clamp, done && result.status == ST_SAT, result.dot_value == 32'sh7fffffff || result.dot_value == 32'sh80000000, "saturated word not clamped")
  `BBM_ASSERT_IMPL(a_no_overfill, q_push, !q_full, "push into full queue")
  `BBM_ASSERT_NEXT(a_pop_frees, q_pop, !q_full, "queue full after pop")

endmodule
`default_nettype wire

@@ sv/bbm_fifo.sv @@
`default_nettype none
module bbm_fifo
  import bbm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t wdata,
  input  wire logic pop,
  output cmd_t      rdata,
  output logic      full,
  output logic      empty
);

  localparam int PW = $clog2(Q_DEPTH);

  cmd_t           slots [Q_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign full  = (count == (PW+1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

@@ sv/bbm_front.sv @@
`default_nettype none
module bbm_front
  import bbm_pkg::*;
#(
  parameter int MEM_DEPTH = 4096,
  parameter int MAX_DIM   = 64,
  parameter int MAX_BATCH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  start,
  input  wire item_t item,
  output logic       busy,
  output logic       q_push,
  output cmd_t       q_cmd,
  input  wire logic  q_full
);

  logic        s1_valid;
  logic        s2_valid;
  logic        adv;
  logic        take;
  item_t       s1_item;
  logic        s1_shape;
  logic        s1_rng;
  logic [10:0] s1_qa;
  logic [10:0] s1_qb;
  logic [11:0] s1_pa;
  logic [11:0] s1_pb;

  logic        keep;
  logic        shape;
  logic        rng;
  logic [4:0]  rb;
  logic [3:0]  ab;
  logic [3:0]  bb;

  logic [18:0] ext_a;
  logic [18:0] ext_b;
  logic [18:0] base_a;
  logic [18:0] base_b;
  logic        rng2;
  cmd_t        cmd_next;

  assign adv    = !s2_valid || !q_full;
  assign busy   = s1_valid && !adv;
  assign take   = start && !busy;
  assign q_push = s2_valid && !q_full;

  // classify
  always_comb begin
    unique case (item.opcode)
      OP_WR_A, OP_WR_B: keep = (32'(item.address) < MEM_DEPTH);
      OP_DOT:           keep = 1'b1;
      default:          keep = 1'b0;
    endcase
    shape = (cfg.batch_a != cfg.batch_b) && (cfg.batch_a != 5'd1) && (cfg.batch_b != 5'd1);
    rb    = (cfg.batch_a > cfg.batch_b) ? cfg.batch_a : cfg.batch_b;
    rng   = (32'(cfg.rows_m) > MAX_DIM) || (32'(cfg.inner_k) > MAX_DIM) ||
            (32'(cfg.cols_n) > MAX_DIM) || (32'(cfg.batch_a) > MAX_BATCH) ||
            (32'(cfg.batch_b) > MAX_BATCH) || (5'(item.batch_index) >= rb) ||
            (7'(item.row_index) >= cfg.rows_m) || (7'(item.col_index) >= cfg.cols_n);
    ab    = (cfg.batch_a == 5'd1) ? 4'd0 : item.batch_index;
    bb    = (cfg.batch_b == 5'd1) ? 4'd0 : item.batch_index;
  end

  // address generation and extent check
  always_comb begin
    ext_a  = 19'(s1_pa) * 19'(cfg.inner_k);
    ext_b  = 19'(s1_pb) * 19'(cfg.cols_n);
    base_a = (19'(s1_qa) + 19'(s1_item.row_index)) * 19'(cfg.inner_k);
    base_b = 19'(s1_qb) * 19'(cfg.cols_n) + 19'(s1_item.col_index);
    rng2   = s1_rng || (32'(ext_a) > MEM_DEPTH) || (32'(ext_b) > MEM_DEPTH);

    cmd_next.addr_a   = base_a[15:0];
    cmd_next.addr_b   = base_b[15:0];
    cmd_next.data     = s1_item.element_value;
    cmd_next.len_k    = cfg.inner_k;
    cmd_next.stride_n = cfg.cols_n;
    cmd_next.status   = ST_OK;
    cmd_next.kind     = CMD_DOT;
    unique case (s1_item.opcode)
      OP_WR_A: begin
        cmd_next.kind   = CMD_WR_A;
        cmd_next.addr_a = 16'(s1_item.address);
      end
      OP_WR_B: begin
        cmd_next.kind   = CMD_WR_B;
        cmd_next.addr_a = 16'(s1_item.address);
      end
      OP_DOT: begin
        priority if (s1_shape) begin
          cmd_next.kind   = CMD_ERR;
          cmd_next.status = ST_SHAPE;
        end else if (rng2) begin
          cmd_next.kind   = CMD_ERR;
          cmd_next.status = ST_RANGE;
        end else begin
          cmd_next.kind   = CMD_DOT;
        end
      end
      default: begin
        cmd_next.kind   = CMD_ERR;
        cmd_next.status = ST_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (adv) begin
        s2_valid <= s1_valid;
      end
      if (adv || !s1_valid) begin
        s1_valid <= take && keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((adv || !s1_valid) && take) begin
      s1_item  <= item;
      s1_shape <= shape;
      s1_rng   <= rng;
      s1_qa    <= 11'(ab) * 11'(cfg.rows_m);
      s1_qb    <= 11'(bb) * 11'(cfg.inner_k);
      s1_pa    <= 12'(cfg.batch_a) * 12'(cfg.rows_m);
      s1_pb    <= 12'(cfg.batch_b) * 12'(cfg.inner_k);
    end
    if (adv && s1_valid) begin
      q_cmd <= cmd_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/bbm_back.sv @@
`default_nettype none
module bbm_back
  import bbm_pkg::*;
#(
  parameter int MEM_DEPTH  = 4096,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  wire cmd_t q_cmd,
  output logic      q_pop,
  output logic      done,
  output result_t   result
);

  localparam int AW    = $clog2(MEM_DEPTH);
  localparam int PW    = 2 * DATA_WIDTH;
  localparam int ACC_W = 64;
  localparam logic signed [ACC_W:0] ACC_MAX = {4'b0001, 61'b0};
  localparam logic signed [ACC_W:0] ACC_MIN = -ACC_MAX;
  localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -64'sd2147483648;

  logic signed [DATA_WIDTH-1:0] mem_a [MEM_DEPTH];
  logic signed [DATA_WIDTH-1:0] mem_b [MEM_DEPTH];

  back_state_t state;
  back_state_t state_next;

  logic [15:0] cur_a;
  logic [15:0] cur_b;
  logic [6:0]  stride;
  logic [6:0]  cnt;
  logic        issue;
  logic        rd_q;
  logic        prod_q;
  logic        done_next;
  logic        err_pop;

  logic signed [DATA_WIDTH-1:0] a_q;
  logic signed [DATA_WIDTH-1:0] b_q;
  logic signed [PW-1:0]         prod;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W:0]        sum;
  logic signed [ACC_W-1:0]      acc_next;
  logic signed [47:0]           wide;
  logic signed [DATA_WIDTH-1:0] elem;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE: begin
        if (!q_empty && q_cmd.kind == CMD_DOT) begin
          state_next = (q_cmd.len_k == 7'd0) ? BS_FIN : BS_RUN;
        end
      end
      BS_RUN: begin
        if (cnt == 7'd1) begin
          state_next = BS_WAIT;
        end
      end
      BS_WAIT: begin
        if (!rd_q && !prod_q) begin
          state_next = BS_FIN;
        end
      end
      BS_FIN:  state_next = BS_IDLE;
      default: state_next = BS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = (state == BS_IDLE) && !q_empty;
    issue     = (state == BS_RUN);
    err_pop   = q_pop && (q_cmd.kind == CMD_ERR);
    done_next = err_pop || (state == BS_FIN);
  end

  always_comb begin
    wide     = 48'(signed'(q_cmd.data));
    elem     = wide[DATA_WIDTH-1:0];
    sum      = (ACC_W+1)'(acc) + (ACC_W+1)'(prod);
    acc_next = (sum > ACC_MAX) ? ACC_MAX[ACC_W-1:0] :
               (sum < ACC_MIN) ? ACC_MIN[ACC_W-1:0] : sum[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.kind == CMD_WR_A) begin
      mem_a[q_cmd.addr_a[AW-1:0]] <= elem;
    end
    if (issue) begin
      a_q <= mem_a[cur_a[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.kind == CMD_WR_B) begin
      mem_b[q_cmd.addr_a[AW-1:0]] <= elem;
    end
    if (issue) begin
      b_q <= mem_b[cur_b[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= BS_IDLE;
      rd_q   <= 1'b0;
      prod_q <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_q   <= issue;
      prod_q <= rd_q;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PW'(a_q) * PW'(b_q);
    if (q_pop) begin
      cur_a  <= q_cmd.addr_a;
      cur_b  <= q_cmd.addr_b;
      stride <= q_cmd.stride_n;
      cnt    <= q_cmd.len_k;
      acc    <= '0;
    end else begin
      if (issue) begin
        cur_a <= cur_a + 16'd1;
        cur_b <= cur_b + 16'(stride);
        cnt   <= cnt - 7'd1;
      end
      if (prod_q) begin
        acc <= acc_next;
      end
    end
    if (err_pop) begin
      result.dot_value <= '0;
      result.status    <= q_cmd.status;
    end else if (state == BS_FIN) begin
      priority if (acc > OUT_MAX) begin
        result.dot_value <= OUT_MAX[31:0];
        result.status    <= ST_SAT;
      end else if (acc < OUT_MIN) begin
        result.dot_value <= OUT_MIN[31:0];
        result.status    <= ST_SAT;
      end else begin
        result.dot_value <= acc[31:0];
        result.status    <= ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
module tb;
  import bbm_pkg::*;

  localparam int MEM_WORDS = 4096;
  localparam int DIM_MAX = 64;
  localparam int BATCH_MAX = 16;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT = 4000;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [6:0] cfg_data;
  logic       start;
  item_t      item;
  logic       busy;
  logic       done;
  result_t    result;

  batched_broadcast_matmul u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .start(start), .item(item), .busy(busy),
    .done(done), .result(result)
  );

  // local copy of the block: stores and shape registers
  logic signed [15:0] a_mem [MEM_WORDS];
  logic signed [15:0] b_mem [MEM_WORDS];
  cfg_t shape;
  result_t dot_expected [$];
  int unsigned errors = 0;
  int unsigned stall_count = 0;
  bit pace_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic bit shape_in_range();
    int unsigned m, k, n, ba, bb;
    m = shape.rows_m; k = shape.inner_k; n = shape.cols_n;
    ba = shape.batch_a; bb = shape.batch_b;
    return !(m > DIM_MAX || k > DIM_MAX || n > DIM_MAX || ba > BATCH_MAX ||
             bb > BATCH_MAX || ba * m * k > MEM_WORDS || bb * k * n > MEM_WORDS);
  endfunction

  function automatic result_t predict_dot(item_t it);
    result_t r;
    int unsigned m, k, n, ba, bb, rb, ab, bbi, base_a, base_b, ia, ib;
    longint acc;
    m = shape.rows_m; k = shape.inner_k; n = shape.cols_n;
    ba = shape.batch_a; bb = shape.batch_b;
    r.dot_value = '0;
    r.status = ST_OK;
    acc = 0;
    rb = (ba > bb) ? ba : bb;
    if (ba != bb && ba != 1 && bb != 1) begin
      r.status = ST_SHAPE;
    end else if (!shape_in_range() || it.batch_index >= rb || it.row_index >= m ||
                 it.col_index >= n) begin
      r.status = ST_RANGE;
    end else begin
      ab = (ba == 1) ? 0 : it.batch_index;
      bbi = (bb == 1) ? 0 : it.batch_index;
      base_a = (ab * m + it.row_index) * k;
      base_b = bbi * k * n + it.col_index;
      for (int unsigned kk = 0; kk < k; kk++) begin
        ia = base_a + kk;
        ib = base_b + kk * n;
        acc += longint'(a_mem[ia]) * longint'(b_mem[ib]);
        if (acc > (longint'(1) <<< 61)) acc = longint'(1) <<< 61;
        if (acc < -(longint'(1) <<< 61)) acc = -(longint'(1) <<< 61);
      end
      if (acc > 64'sd2147483647) begin
        r.dot_value = 32'sh7fffffff;
        r.status = ST_SAT;
      end else if (acc < -64'sd2147483648) begin
        r.dot_value = 32'sh80000000;
        r.status = ST_SAT;
      end else begin
        r.dot_value = acc[31:0];
      end
    end
    return r;
  endfunction

  function automatic item_t make_item(opcode_t op, logic [11:0] addr, logic [15:0] val,
                                      logic [3:0] bi, logic [5:0] ri, logic [5:0] ci);
    item_t it;
    it.opcode = op;
    it.address = addr;
    it.element_value = val;
    it.batch_index = bi;
    it.row_index = ri;
    it.col_index = ci;
    return it;
  endfunction

  function automatic logic [15:0] rand_element();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = pace_on ? $urandom_range(0, 11) : 0;
    repeat (gap) @(negedge clk);
    start = 1'b1;
    item = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    case (it.opcode)
      OP_WR_A: a_mem[it.address] = it.element_value;
      OP_WR_B: b_mem[it.address] = it.element_value;
      OP_DOT:  dot_expected = {dot_expected, predict_dot(it)};
      default: ;
    endcase
    @(negedge clk);
    start = 1'b0;
    item = make_item(OP_NOP, 12'($urandom), 16'($urandom), 4'($urandom), 6'($urandom),
                     6'($urandom));
  endtask

  // wait out results and any write still in flight
  task automatic drain();
    while (dot_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [6:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      REG_ROWS_M:  shape.rows_m = val;
      REG_INNER_K: shape.inner_k = val;
      REG_COLS_N:  shape.cols_n = val;
      REG_BATCH_A: shape.batch_a = val[4:0];
      REG_BATCH_B: shape.batch_b = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // reprogram, then load every element a compute can reach
  task automatic set_shape(input int m, input int k, input int n, input int ba,
                           input int bb);
    int ext_a, ext_b;
    drain();
    cfg_write(REG_ROWS_M, 7'(m));
    cfg_write(REG_INNER_K, 7'(k));
    cfg_write(REG_COLS_N, 7'(n));
    cfg_write(REG_BATCH_A, 7'(ba));
    cfg_write(REG_BATCH_B, 7'(bb));
    if (shape_in_range()) begin
      ext_a = shape.batch_a * shape.rows_m * shape.inner_k;
      ext_b = shape.batch_b * shape.inner_k * shape.cols_n;
      for (int i = 0; i < ext_a; i++)
        send_item(make_item(OP_WR_A, 12'(i), rand_element(), '0, '0, '0));
      for (int i = 0; i < ext_b; i++)
        send_item(make_item(OP_WR_B, 12'(i), rand_element(), '0, '0, '0));
    end
  endtask

  function automatic item_t random_dot(bit legal);
    int unsigned rb;
    rb = (shape.batch_a > shape.batch_b) ? shape.batch_a : shape.batch_b;
    if (!legal || rb == 0 || shape.rows_m == 0 || shape.cols_n == 0 ||
        rb > BATCH_MAX || shape.rows_m > DIM_MAX || shape.cols_n > DIM_MAX)
      return make_item(OP_DOT, 12'($urandom), 16'($urandom), 4'($urandom),
                       6'($urandom), 6'($urandom));
    return make_item(OP_DOT, 12'($urandom), 16'($urandom), 4'($urandom_range(0, rb - 1)),
                     6'($urandom_range(0, shape.rows_m - 1)),
                     6'($urandom_range(0, shape.cols_n - 1)));
  endfunction

  task automatic random_traffic(input int count);
    int ext_a, ext_b, pick;
    ext_a = shape.batch_a * shape.rows_m * shape.inner_k;
    ext_b = shape.batch_b * shape.inner_k * shape.cols_n;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)
        send_item(make_item(OP_WR_A, 12'($urandom_range(0, ext_a - 1)), rand_element(),
                            4'($urandom), 6'($urandom), 6'($urandom)));
      else if (pick < 60)
        send_item(make_item(OP_WR_B, 12'($urandom_range(0, ext_b - 1)), rand_element(),
                            4'($urandom), 6'($urandom), 6'($urandom)));
      else if (pick < 93)
        send_item(random_dot(1'b1));
      else if (pick < 96)
        send_item(random_dot(1'b0));
      else if (pick < 98)
        send_item(make_item(OP_NOP, 12'($urandom), 16'($urandom), 4'($urandom),
                            6'($urandom), 6'($urandom)));
      else
        send_item(make_item(opcode_t'($urandom_range(0, 1)), 12'($urandom),
                            16'($urandom), 4'($urandom), 6'($urandom), 6'($urandom)));
    end
  endtask

  task automatic test_reset_shape();
    send_item(make_item(OP_WR_A, 12'd0, 16'h7fff, '0, '0, '0));
    send_item(make_item(OP_WR_B, 12'd0, 16'h8000, '0, '0, '0));
    send_item(make_item(OP_DOT, '0, '0, 4'd0, 6'd0, 6'd0));
    send_item(make_item(OP_DOT, '0, '0, 4'd1, 6'd0, 6'd0));
    send_item(make_item(OP_DOT, '0, '0, 4'd0, 6'd1, 6'd0));
    send_item(make_item(OP_DOT, '0, '0, 4'd0, 6'd0, 6'd63));
    send_item(make_item(OP_NOP, 12'hfff, 16'hffff, 4'hf, 6'h3f, 6'h3f));
    send_item(make_item(OP_WR_A, 12'd0, 16'h8000, '0, '0, '0));
    send_item(make_item(OP_DOT, 12'hfff, 16'hffff, 4'd0, 6'd0, 6'd0));
  endtask

  task automatic test_saturation();
    set_shape(1, 4, 1, 1, 1);
    for (int i = 0; i < 4; i++) begin
      send_item(make_item(OP_WR_A, 12'(i), 16'h8000, '0, '0, '0));
      send_item(make_item(OP_WR_B, 12'(i), 16'h8000, '0, '0, '0));
    end
    send_item(make_item(OP_DOT, '0, '0, '0, '0, '0));
    for (int i = 0; i < 4; i++)
      send_item(make_item(OP_WR_B, 12'(i), 16'h7fff, '0, '0, '0));
    send_item(make_item(OP_DOT, '0, '0, '0, '0, '0));
  endtask

  task automatic test_error_shapes();
    int m [5] = '{2, 0, 127, 64, 1};
    int k [5] = '{2, 1, 127, 64, 1};
    int n [5] = '{2, 1, 127, 2, 1};
    int ba [5] = '{3, 1, 31, 2, 17};
    int bb [5] = '{5, 1, 31, 1, 1};
    for (int p = 0; p < 5; p++) begin
      set_shape(m[p], k[p], n[p], ba[p], bb[p]);
      for (int i = 0; i < 12; i++) send_item(random_dot(1'b0));
    end
  endtask

  task automatic test_random_shapes();
    int m [9] = '{2, 3, 2, 64, 1, 4, 1, 5, 2};
    int k [9] = '{3, 2, 2, 1, 64, 8, 1, 3, 0};
    int n [9] = '{2, 4, 2, 64, 1, 4, 1, 2, 3};
    int ba [9] = '{4, 1, 16, 1, 1, 3, 1, 2, 2};
    int bb [9] = '{1, 4, 16, 1, 1, 3, 1, 2, 1};
    for (int p = 0; p < 9; p++) begin
      pace_on = (p % 3) != 1;
      set_shape(m[p], k[p], n[p], ba[p], bb[p]);
      if (k[p] == 0) begin
        for (int i = 0; i < 20; i++) send_item(random_dot(1'b1));
      end else begin
        random_traffic(70);
      end
    end
    pace_on = 1'b1;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (dot_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", result.dot_value));
      end else begin
        want = dot_expected.pop_front();
        if (result.dot_value !== want.dot_value)
          report_mismatch($sformatf("dot_value %0d, want %0d", result.dot_value,
                                    want.dot_value));
        if (result.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", result.status, want.status));
      end
    end
  end

  // nothing moving for too long means a hang
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    start = 1'b0;
    item = '0;
    shape.rows_m = 7'd1;
    shape.inner_k = 7'd1;
    shape.cols_n = 7'd1;
    shape.batch_a = 5'd1;
    shape.batch_b = 5'd1;
    repeat (7) @(negedge clk);
    rst = 1'b0;
    test_reset_shape();
    test_saturation();
    test_error_shapes();
    test_random_shapes();
    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
